>>> src/stream_find_and_replace_macros.svh
// ----------------------------------------------------------------------------
// stream find and replace assertion macros
// shared concurrent assertion forms for the rtl of the block
// ----------------------------------------------------------------------------
`ifndef STREAM_FIND_AND_REPLACE_MACROS_SVH
`define STREAM_FIND_AND_REPLACE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SFR_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SFR_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types and constants of the stream find and replace block
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 5;
    localparam int PAT_REG_BYTES = 16;
    localparam int REP_REG_BYTES = 24;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_ADDR_W    = 6;
    localparam int REG_IDX_W     = 3;

    // register indexes (byte address is 8 times the index)
    localparam logic [REG_IDX_W-1:0] REG_PAT_LO  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAT_HI  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PAT_LEN = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_REP_LO  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REP_MID = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_REP_TOP = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_REP_LEN = 3'd6;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [PAT_REG_BYTES*BYTE_W-1:0] pattern;
        logic [LEN_W-1:0]                pat_len;
        logic [REP_REG_BYTES*BYTE_W-1:0] replacement;
        logic [LEN_W-1:0]                rep_len;
    } cfg_t;

    // what one source word produces, handed from matcher to emitter
    typedef struct packed {
        logic              evict;
        logic [BYTE_W-1:0] evict_byte;
        logic              hit;
        logic [LEN_W-1:0]  flush_cnt;
        logic              eos;
    } desc_t;

endpackage

>>> src/sfr_in_if.sv
// ----------------------------------------------------------------------------
// sfr_in_if
// source byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface sfr_in_if
    import sfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

>>> src/sfr_out_if.sv
// ----------------------------------------------------------------------------
// sfr_out_if
// rewritten byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface sfr_out_if
    import sfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last_of_string;

    modport source (output valid, output out_byte, output byte_valid,
                    output last_of_string, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input last_of_string, output ready);
endinterface

>>> src/sfr_regs.sv
// ----------------------------------------------------------------------------
// sfr_regs
// apb register file holding pattern and replacement settings
// ----------------------------------------------------------------------------
module sfr_regs
    import sfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg,
    output logic                  pat_len_wr
);

    logic [CFG_DATA_W-1:0] pat_lo_reg;
    logic [CFG_DATA_W-1:0] pat_hi_reg;
    logic [LEN_W-1:0]      pat_len_reg;
    logic [CFG_DATA_W-1:0] rep_lo_reg;
    logic [CFG_DATA_W-1:0] rep_mid_reg;
    logic [CFG_DATA_W-1:0] rep_top_reg;
    logic [LEN_W-1:0]      rep_len_reg;
    logic                  wr_en;
    logic [REG_IDX_W-1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[CFG_ADDR_W-1:3];

    assign pat_len_wr = wr_en && (reg_idx == REG_PAT_LEN);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg  <= '0;
            pat_hi_reg  <= '0;
            pat_len_reg <= '0;
            rep_lo_reg  <= '0;
            rep_mid_reg <= '0;
            rep_top_reg <= '0;
            rep_len_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_PAT_LO:  pat_lo_reg  <= pwdata;
                REG_PAT_HI:  pat_hi_reg  <= pwdata;
                REG_PAT_LEN: pat_len_reg <= pwdata[LEN_W-1:0];
                REG_REP_LO:  rep_lo_reg  <= pwdata;
                REG_REP_MID: rep_mid_reg <= pwdata;
                REG_REP_TOP: rep_top_reg <= pwdata;
                REG_REP_LEN: rep_len_reg <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_idx)
            REG_PAT_LO:  prdata = pat_lo_reg;
            REG_PAT_HI:  prdata = pat_hi_reg;
            REG_PAT_LEN: prdata = CFG_DATA_W'(pat_len_reg);
            REG_REP_LO:  prdata = rep_lo_reg;
            REG_REP_MID: prdata = rep_mid_reg;
            REG_REP_TOP: prdata = rep_top_reg;
            REG_REP_LEN: prdata = CFG_DATA_W'(rep_len_reg);
            default:     prdata = '0;
        endcase
    end

    assign cfg.pattern     = {pat_hi_reg, pat_lo_reg};
    assign cfg.pat_len     = pat_len_reg;
    assign cfg.replacement = {rep_top_reg, rep_mid_reg, rep_lo_reg};
    assign cfg.rep_len     = rep_len_reg;

endmodule

>>> src/sfr_match.sv
// ----------------------------------------------------------------------------
// sfr_match
// input register, match window and pattern compare
// ----------------------------------------------------------------------------
`include "stream_find_and_replace_macros.svh"

module sfr_match
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int IDX_W             = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    sfr_in_if.sink            in_ch,
    input  cfg_t              cfg,
    input  logic              pat_len_wr,
    input  logic              desc_ready,
    output logic              desc_load,
    output desc_t             desc,
    input  logic [IDX_W-1:0]  flush_idx,
    output logic [BYTE_W-1:0] flush_byte
);

    logic              in_vld_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_eos_reg;
    logic [BYTE_W-1:0] win_reg [MAX_PATTERN_BYTES];
    logic [LEN_W-1:0]  fill_reg;
    logic [LEN_W-1:0]  fill_next;

    logic [BYTE_W-1:0] pat_arr [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0] win_shift [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0] win_next [MAX_PATTERN_BYTES];
    logic [LEN_W-1:0]  plen;
    logic              pass_thru;
    logic [LEN_W-1:0]  fill_start;
    logic              full;
    logic [LEN_W-1:0]  fill_ins;
    logic [LEN_W-1:0]  fill_after;
    logic              all_eq;
    logic              hit;
    logic [LEN_W-1:0]  fill_done;

    // input register, refilled whenever the word in it moves on
    assign in_ch.ready = !in_vld_reg || desc_ready;
    assign desc_load   = in_vld_reg && desc_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_vld_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_byte_reg <= in_ch.in_byte;
            in_eos_reg  <= in_ch.end_of_string;
        end
    end

    // pattern bytes past the register bytes read as zero
    for (genvar i = 0; i < MAX_PATTERN_BYTES; i++)
    begin : g_pat
        if (i < PAT_REG_BYTES)
        begin : g_reg
            assign pat_arr[i] = cfg.pattern[i*BYTE_W +: BYTE_W];
        end
        else
        begin : g_zero
            assign pat_arr[i] = '0;
        end
    end

    // effective pattern length
    assign plen = (int'(cfg.pat_len) > MAX_PATTERN_BYTES) ? LEN_W'(MAX_PATTERN_BYTES)
                                                          : cfg.pat_len;
    assign pass_thru = (plen == '0);

    // evict, shift, insert and compare in one pass
    always_comb
    begin
        fill_start = (fill_reg > plen) ? '0 : fill_reg;
        full       = !pass_thru && (fill_start == plen);

        for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++)
        begin
            win_shift[i] = full ? win_reg[i+1] : win_reg[i];
        end
        win_shift[MAX_PATTERN_BYTES-1] = win_reg[MAX_PATTERN_BYTES-1];

        fill_ins   = fill_start - LEN_W'(full);
        win_next   = win_shift;
        win_next[IDX_W'(fill_ins)] = in_byte_reg;
        fill_after = fill_ins + LEN_W'(1);

        all_eq = 1'b1;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            if ((i < int'(plen)) && (win_next[i] != pat_arr[i]))
            begin
                all_eq = 1'b0;
            end
        end

        hit       = !pass_thru && (fill_after == plen) && all_eq;
        fill_done = hit ? '0 : fill_after;

        if (pass_thru)
        begin
            fill_next = fill_reg;
        end
        else if (in_eos_reg)
        begin
            fill_next = '0;
        end
        else
        begin
            fill_next = fill_done;
        end
    end

    // work handed to the emitter
    assign desc.evict      = pass_thru || full;
    assign desc.evict_byte = pass_thru ? in_byte_reg : win_reg[0];
    assign desc.hit        = hit;
    assign desc.flush_cnt  = (!pass_thru && in_eos_reg) ? fill_done : '0;
    assign desc.eos        = in_eos_reg;

    // window state; a new pattern length empties the window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            for (int i = 0; i < MAX_PATTERN_BYTES; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (pat_len_wr)
        begin
            fill_reg <= '0;
        end
        else if (desc_load)
        begin
            fill_reg <= fill_next;
            if (!pass_thru)
            begin
                win_reg <= win_next;
            end
        end
    end

    assign flush_byte = win_reg[flush_idx];

    `SFR_ASSERT_NEXT(a_hit_empties_window, clk, rst_n, desc_load && hit, fill_reg == '0, "window not emptied after a match")
    `SFR_ASSERT_NEXT(a_end_empties_window, clk, rst_n, desc_load && in_eos_reg && !pass_thru, fill_reg == '0, "window not flushed at end of string")

endmodule

>>> src/sfr_emit.sv
// ----------------------------------------------------------------------------
// sfr_emit
// walks the results of one word into the output register
// ----------------------------------------------------------------------------
`include "stream_find_and_replace_macros.svh"

module sfr_emit
    import sfr_pkg::*;
#(
    parameter int MAX_REPLACEMENT_BYTES = 24,
    parameter int IDX_W                 = 4,
    parameter int CNT_W                 = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              desc_load,
    input  desc_t             desc,
    output logic              desc_ready,
    output logic [IDX_W-1:0]  flush_idx,
    input  logic [BYTE_W-1:0] flush_byte,
    sfr_out_if.source         out_ch
);

    localparam int REP_IDX_W = (MAX_REPLACEMENT_BYTES > 1) ? $clog2(MAX_REPLACEMENT_BYTES) : 1;

    desc_t             desc_reg;
    logic [CNT_W-1:0]  left_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic              out_vld_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_byte_valid_reg;
    logic              out_last_reg;

    logic [BYTE_W-1:0] rep_arr [MAX_REPLACEMENT_BYTES];
    logic [LEN_W-1:0]  rl;
    logic [CNT_W-1:0]  rl_new;
    logic [CNT_W-1:0]  rl_cur;
    logic [CNT_W-1:0]  n_raw;
    logic [CNT_W-1:0]  n_total;
    logic              pop;
    logic              is_ev;
    logic              is_rep;
    logic              is_fl;
    logic [CNT_W-1:0]  p_rep;
    logic [CNT_W-1:0]  p_fl;
    logic [BYTE_W-1:0] sel_byte;

    // replacement bytes past the register bytes read as zero
    for (genvar i = 0; i < MAX_REPLACEMENT_BYTES; i++)
    begin : g_rep
        if (i < REP_REG_BYTES)
        begin : g_reg
            assign rep_arr[i] = cfg.replacement[i*BYTE_W +: BYTE_W];
        end
        else
        begin : g_zero
            assign rep_arr[i] = '0;
        end
    end

    assign rl = (int'(cfg.rep_len) > MAX_REPLACEMENT_BYTES) ? LEN_W'(MAX_REPLACEMENT_BYTES)
                                                            : cfg.rep_len;

    // number of results for an incoming word
    always_comb
    begin
        rl_new  = desc.hit ? CNT_W'(rl) : '0;
        n_raw   = CNT_W'(desc.evict) + rl_new + CNT_W'(desc.flush_cnt);
        n_total = (desc.eos && (n_raw == '0)) ? CNT_W'(1) : n_raw;
    end

    // handshake between the sequencer and the output register
    assign pop        = (left_reg != '0) && (!out_vld_reg || out_ch.ready);
    assign desc_ready = (left_reg == '0) || ((left_reg == CNT_W'(1)) && pop);

    // pick the result at the current position
    always_comb
    begin
        rl_cur    = desc_reg.hit ? CNT_W'(rl) : '0;
        is_ev     = desc_reg.evict && (pos_reg == '0);
        p_rep     = pos_reg - CNT_W'(desc_reg.evict);
        is_rep    = !is_ev && (p_rep < rl_cur);
        p_fl      = p_rep - rl_cur;
        is_fl     = !is_ev && !is_rep && (p_fl < CNT_W'(desc_reg.flush_cnt));
        flush_idx = IDX_W'(p_fl);
        if (is_ev)
        begin
            sel_byte = desc_reg.evict_byte;
        end
        else if (is_rep)
        begin
            sel_byte = rep_arr[REP_IDX_W'(p_rep)];
        end
        else if (is_fl)
        begin
            sel_byte = flush_byte;
        end
        else
        begin
            sel_byte = '0;
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            pos_reg  <= '0;
        end
        else if (desc_load)
        begin
            left_reg <= n_total;
            pos_reg  <= '0;
        end
        else if (pop)
        begin
            left_reg <= left_reg - CNT_W'(1);
            pos_reg  <= pos_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_load)
        begin
            desc_reg <= desc;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_byte_reg       <= sel_byte;
            out_byte_valid_reg <= is_ev || is_rep || is_fl;
            out_last_reg       <= desc_reg.eos && (left_reg == CNT_W'(1));
        end
    end

    assign out_ch.valid          = out_vld_reg;
    assign out_ch.out_byte       = out_byte_reg;
    assign out_ch.byte_valid     = out_byte_valid_reg;
    assign out_ch.last_of_string = out_last_reg;

    `SFR_ASSERT_SAME(a_marker_is_last, clk, rst_n, out_vld_reg && !out_byte_valid_reg, out_last_reg, "empty word that does not end a string")
    `SFR_ASSERT_NEXT(a_end_word_last, clk, rst_n, pop && (left_reg == CNT_W'(1)) && desc_reg.eos, out_vld_reg && out_last_reg, "final result of a string not marked last")
    `SFR_ASSERT_NEXT(a_stall_holds_seq, clk, rst_n, out_vld_reg && !out_ch.ready && (left_reg != '0), $stable(pos_reg) && $stable(left_reg), "sequencer moved while output stalled")

endmodule

>>> src/stream_find_and_replace.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace
// replaces every leftmost non-overlapping pattern match in a byte stream
// ----------------------------------------------------------------------------
//  channel   dir  handshake         payload
//  in_ch     in   valid / ready     in_byte, end_of_string
//  out_ch    out  valid / ready     out_byte, byte_valid, last_of_string
//  apb       in   psel / penable    paddr, pwdata, prdata (64 bit registers)
//
//  every result of a source word is an output word of its own; a word
//  with one result or none moves on without waiting on a burst, so plain
//  text streams at one word per cycle while out_ch is not stalled, and a
//  match holds the input through its burst (up to 25 results for one word).
//  reset clears the registers, the window and all valid flags.
//  a stall on out_ch holds the output register and backs up into in_ch.
// ----------------------------------------------------------------------------
module stream_find_and_replace
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES     = 16,
    parameter int MAX_REPLACEMENT_BYTES = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    sfr_in_if.sink                in_ch,
    sfr_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int CNT_W = $clog2(MAX_PATTERN_BYTES + MAX_REPLACEMENT_BYTES + 2);

    cfg_t              cfg;
    logic              pat_len_wr;
    logic              desc_ready;
    logic              desc_load;
    desc_t             desc;
    logic [IDX_W-1:0]  flush_idx;
    logic [BYTE_W-1:0] flush_byte;

    // configuration registers
    sfr_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cfg        (cfg),
        .pat_len_wr (pat_len_wr)
    );

    // window and compare
    sfr_match #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .IDX_W             (IDX_W)
    ) u_match (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg        (cfg),
        .pat_len_wr (pat_len_wr),
        .desc_ready (desc_ready),
        .desc_load  (desc_load),
        .desc       (desc),
        .flush_idx  (flush_idx),
        .flush_byte (flush_byte)
    );

    // result sequencing and output register
    sfr_emit #(
        .MAX_REPLACEMENT_BYTES (MAX_REPLACEMENT_BYTES),
        .IDX_W                 (IDX_W),
        .CNT_W                 (CNT_W)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .desc_load  (desc_load),
        .desc       (desc),
        .desc_ready (desc_ready),
        .flush_idx  (flush_idx),
        .flush_byte (flush_byte),
        .out_ch     (out_ch)
    );

endmodule

>>> tb/sv/sfr_rewrite_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_rewrite_checker
// watches the source, output and register channels of the find and replace
// block, rebuilds the expected rewritten stream from every accepted source
// word and register write, and compares each accepted output word with it
// ----------------------------------------------------------------------------
module sfr_rewrite_checker
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES     = 16,
    parameter int MAX_REPLACEMENT_BYTES = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [BYTE_W-1:0]     in_byte,
    input  logic                  in_eos,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [BYTE_W-1:0]     out_byte,
    input  logic                  out_byte_valid,
    input  logic                  out_last,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output int                    fail_count,
    output int                    expected_count
);

    localparam int NUM_REGS = 7;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              last_of_string;
    } rewritten_word_t;

    // register copy and match window as the block should hold them
    logic [CFG_DATA_W-1:0] shadow_regs [NUM_REGS];
    logic [BYTE_W-1:0]     hold_window [MAX_PATTERN_BYTES];
    int                    hold_count;
    rewritten_word_t       rewritten_q [$];
    int                    fail_total;
    int                    out_words;

    function automatic rewritten_word_t make_word(input logic [BYTE_W-1:0] data,
                                                  input logic valid);
        rewritten_word_t w;
        w.out_byte       = data;
        w.byte_valid     = valid;
        w.last_of_string = 1'b0;
        return w;
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_byte(input int i);
        return shadow_regs[int'(REG_PAT_LO) + i / 8][(i % 8) * 8 +: 8];
    endfunction

    function automatic logic [BYTE_W-1:0] replacement_byte(input int i);
        return shadow_regs[int'(REG_REP_LO) + i / 8][(i % 8) * 8 +: 8];
    endfunction

    // expected output words for one source word
    function automatic void rewrite_word(input logic [BYTE_W-1:0] b, input logic eos);
        rewritten_word_t burst [$];
        rewritten_word_t tail;
        int              plen;
        int              rlen;
        bit              hit;
        plen = int'(shadow_regs[REG_PAT_LEN][LEN_W-1:0]);
        rlen = int'(shadow_regs[REG_REP_LEN][LEN_W-1:0]);
        if (plen > MAX_PATTERN_BYTES)
            plen = MAX_PATTERN_BYTES;
        if (rlen > MAX_REPLACEMENT_BYTES)
            rlen = MAX_REPLACEMENT_BYTES;

        if (plen == 0)
        begin
            burst.push_back(make_word(b, 1'b1));
        end
        else
        begin
            if (hold_count > plen)
                hold_count = 0;
            // full window: oldest byte leaves first
            if (hold_count == plen)
            begin
                burst.push_back(make_word(hold_window[0], 1'b1));
                for (int k = 0; k < MAX_PATTERN_BYTES - 1; k++)
                    hold_window[k] = hold_window[k + 1];
                hold_count--;
            end
            hold_window[hold_count] = b;
            hold_count++;
            // window equals pattern: emit replacement, clear window
            if (hold_count == plen)
            begin
                hit = 1'b1;
                for (int k = 0; k < plen; k++)
                    if (hold_window[k] != pattern_byte(k))
                        hit = 1'b0;
                if (hit)
                begin
                    for (int k = 0; k < rlen; k++)
                        burst.push_back(make_word(replacement_byte(k), 1'b1));
                    hold_count = 0;
                end
            end
            // end of string flushes the window
            if (eos)
            begin
                for (int k = 0; k < hold_count; k++)
                    burst.push_back(make_word(hold_window[k], 1'b1));
                hold_count = 0;
            end
        end

        // mark the final word, or an empty end marker if nothing came out
        if (eos)
        begin
            if (burst.size() == 0)
                burst.push_back(make_word('0, 1'b0));
            tail = burst.pop_back();
            tail.last_of_string = 1'b1;
            burst.push_back(tail);
        end
        foreach (burst[k])
            rewritten_q.push_back(burst[k]);
    endfunction

    // register write as seen on the port
    function automatic void apply_write(input logic [CFG_ADDR_W-1:0] addr,
                                        input logic [CFG_DATA_W-1:0] data);
        logic [REG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] value;
        idx   = addr[CFG_ADDR_W-1:3];
        value = data;
        if (int'(idx) >= NUM_REGS)
            return;
        if (idx == REG_PAT_LEN || idx == REG_REP_LEN)
            value = value & CFG_DATA_W'(5'h1f);
        shadow_regs[idx] = value;
        if (idx == REG_PAT_LEN)
            hold_count = 0;
    endfunction

    // compare, then predict: a word accepted at this edge cannot show up yet
    always @(posedge clk or negedge rst_n)
    begin
        rewritten_word_t want;
        if (!rst_n)
        begin
            foreach (shadow_regs[r])
                shadow_regs[r] = '0;
            foreach (hold_window[k])
                hold_window[k] = '0;
            hold_count = 0;
            rewritten_q.delete();
            fail_total = 0;
            out_words  = 0;
            fail_count     <= 0;
            expected_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (rewritten_q.size() == 0)
                begin
                    if (fail_total < 10)
                        $display("output word %0d: none expected, got byte %h valid %b last %b",
                                 out_words, out_byte, out_byte_valid, out_last);
                    fail_total++;
                end
                else
                begin
                    want = rewritten_q.pop_front();
                    if (want.out_byte !== out_byte || want.byte_valid !== out_byte_valid ||
                        want.last_of_string !== out_last)
                    begin
                        if (fail_total < 10)
                            $display("output word %0d: expected byte %h valid %b last %b, %s",
                                     out_words, want.out_byte, want.byte_valid,
                                     want.last_of_string,
                                     $sformatf("got byte %h valid %b last %b",
                                               out_byte, out_byte_valid, out_last));
                        fail_total++;
                    end
                end
                out_words++;
            end
            if (psel && penable && pwrite && pready)
                apply_write(paddr, pwdata);
            if (in_valid && in_ready)
                rewrite_word(in_byte, in_eos);
            fail_count     <= fail_total;
            expected_count <= rewritten_q.size();
        end
    end

endmodule

>>> tb/sv/tb_stream_find_and_replace.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stream_find_and_replace
// drives source strings and register settings into the find and replace
// block with random gaps and output stalls; a checker beside the block
// predicts and compares every output word, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_stream_find_and_replace;
    import sfr_pkg::*;

    localparam int MAX_PATTERN_BYTES     = 16;
    localparam int MAX_REPLACEMENT_BYTES = 24;
    localparam int NUM_PHASES            = 9;
    localparam int PHASE_WORDS           = 30;
    localparam int DRAIN_CYCLES          = 12;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    expected_count;
    int unsigned           cycle_count = 0;

    // pattern in force, used to build strings that hit it
    logic [PAT_REG_BYTES*BYTE_W-1:0] cur_pattern;
    int                              cur_plen;
    bit                              cur_narrow;
    int                              random_words;

    sfr_in_if  in_ch ();
    sfr_out_if out_ch ();

    stream_find_and_replace #(
        .MAX_PATTERN_BYTES     (MAX_PATTERN_BYTES),
        .MAX_REPLACEMENT_BYTES (MAX_REPLACEMENT_BYTES)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sfr_rewrite_checker #(
        .MAX_PATTERN_BYTES     (MAX_PATTERN_BYTES),
        .MAX_REPLACEMENT_BYTES (MAX_REPLACEMENT_BYTES)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_ch.valid),
        .in_ready       (in_ch.ready),
        .in_byte        (in_ch.in_byte),
        .in_eos         (in_ch.end_of_string),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .out_byte       (out_ch.out_byte),
        .out_byte_valid (out_ch.byte_valid),
        .out_last       (out_ch.last_of_string),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .fail_count     (fail_count),
        .expected_count (expected_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // output stalls, with stretches of no stall at all
    initial
    begin
        int run;
        int stall;
        out_ch.ready = 1'b1;
        @(posedge clk iff rst_n);
        forever
        begin
            run = ($urandom_range(0, 9) < 2) ? $urandom_range(40, 120) : $urandom_range(1, 8);
            repeat (run) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    // one source word, then maybe a gap
    task automatic send_word(input logic [BYTE_W-1:0] b, input logic eos);
        int gap;
        in_ch.valid         <= 1'b1;
        in_ch.in_byte       <= b;
        in_ch.end_of_string <= eos;
        do @(posedge clk); while (!in_ch.ready);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold the source until every expected word has come out
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // length value with random upper bits, which the block must drop
    function automatic logic [CFG_DATA_W-1:0] len_word(input int len);
        logic [CFG_DATA_W-1:0] w;
        w = {$urandom(), $urandom()};
        w[LEN_W-1:0] = LEN_W'(len);
        return w;
    endfunction

    task automatic load_config(input logic [PAT_REG_BYTES*BYTE_W-1:0] pat, input int plen,
                               input logic [REP_REG_BYTES*BYTE_W-1:0] rep, input int rlen);
        write_reg(REG_PAT_LO, pat[63:0]);
        write_reg(REG_PAT_HI, pat[127:64]);
        write_reg(REG_PAT_LEN, len_word(plen));
        write_reg(REG_REP_LO, rep[63:0]);
        write_reg(REG_REP_MID, rep[127:64]);
        write_reg(REG_REP_TOP, rep[191:128]);
        write_reg(REG_REP_LEN, len_word(rlen));
        cur_pattern = pat;
        cur_plen    = (plen > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : plen;
    endtask

    function automatic logic [BYTE_W-1:0] filler_byte();
        if (cur_narrow)
            return $urandom_range(0, 1) ? 8'h61 : 8'h62;
        return BYTE_W'($urandom());
    endfunction

    // string made of whole matches, partial matches and loose bytes
    task automatic send_string();
        logic [BYTE_W-1:0] text [$];
        int                len_goal;
        int                pick;
        int                cut;
        bit                closed;
        len_goal = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        closed   = ($urandom_range(0, 9) != 0);
        while (text.size() < len_goal)
        begin
            pick = $urandom_range(0, 99);
            if (cur_plen > 0 && pick < 40)
                cut = cur_plen;
            else if (cur_plen > 1 && pick < 55)
                cut = $urandom_range(1, cur_plen - 1);
            else
                cut = 0;
            for (int k = 0; k < cut; k++)
                text.push_back(cur_pattern[k * BYTE_W +: BYTE_W]);
            if (cut == 0)
                text.push_back((pick < 80) ? filler_byte() : BYTE_W'($urandom()));
        end
        foreach (text[k])
            send_word(text[k], closed && (k == text.size() - 1));
        random_words += text.size();
    endtask

    task automatic run_directed();
        // pass through straight after reset, both byte extremes
        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b1);
        wait_idle();
        // write to a register index that does not exist
        write_reg(REG_UNUSED, '1);
        // pattern "ab", replacement "XYZ"
        load_config(128'h6261, 2, 192'h5a5958, 3);
        send_word(8'h78, 1'b0);
        send_word(8'h61, 1'b0);
        send_word(8'h62, 1'b0);
        send_word(8'h79, 1'b1);
        // partial match flushed at the end of the string
        send_word(8'h61, 1'b1);
        // match as the final word of the string
        send_word(8'h61, 1'b0);
        send_word(8'h62, 1'b1);
        // rewriting the pattern length drops a half filled window
        send_word(8'h61, 1'b0);
        wait_idle();
        write_reg(REG_PAT_LEN, len_word(2));
        send_word(8'h62, 1'b1);
        wait_idle();
        // empty replacement at the end of a string gives an empty end marker
        write_reg(REG_REP_LEN, len_word(0));
        send_word(8'h61, 1'b0);
        send_word(8'h62, 1'b1);
        wait_idle();
    endtask

    task automatic run_random();
        logic [PAT_REG_BYTES*BYTE_W-1:0] pat;
        logic [REP_REG_BYTES*BYTE_W-1:0] rep;
        int                              plen;
        int                              rlen;
        int                              budget_end;
        random_words = 0;
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    plen = 0; rlen = $urandom_range(0, 24); cur_narrow = 1'b0;
                end
                1:
                begin
                    plen = 1; rlen = 24; cur_narrow = 1'b1;
                end
                2:
                begin
                    plen = 16; rlen = 24; cur_narrow = 1'b0;
                end
                3:
                begin
                    // lengths above the maximum saturate
                    plen = $urandom_range(17, 31); rlen = $urandom_range(25, 31);
                    cur_narrow = 1'b0;
                end
                4:
                begin
                    plen = 2; rlen = 0; cur_narrow = 1'b1;
                end
                5:
                begin
                    plen = 16; rlen = 1; cur_narrow = 1'b1;
                end
                default:
                begin
                    plen = $urandom_range(1, 6); rlen = $urandom_range(0, 24);
                    cur_narrow = 1'b1;
                end
            endcase
            for (int k = 0; k < PAT_REG_BYTES; k++)
                pat[k * BYTE_W +: BYTE_W] = filler_byte();
            for (int k = 0; k < REP_REG_BYTES; k++)
                rep[k * BYTE_W +: BYTE_W] = BYTE_W'($urandom());
            wait_idle();
            load_config(pat, plen, rep, rlen);
            budget_end = random_words + PHASE_WORDS;
            while (random_words < budget_end)
            begin
                send_string();
                if ($urandom_range(0, 19) == 0)
                    wait_idle();
            end
        end
    endtask

    // reset, directed words, random phases, verdict
    initial
    begin
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.in_byte       = '0;
        in_ch.end_of_string = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        cur_pattern         = '0;
        cur_plen            = 0;
        cur_narrow          = 1'b0;
        random_words        = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        wait_idle();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
